// File: rtl/cross_correlation_lag_search_defines.svh
// ----------------------------------------------------------------------------
// Cross-correlation lag search: assertion macros
// Shared property forms for the assertions of the lag search design.
// ----------------------------------------------------------------------------
`ifndef CROSS_CORRELATION_LAG_SEARCH_DEFINES_SVH
`define CROSS_CORRELATION_LAG_SEARCH_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define XCLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define XCLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/xcls_pkg.sv
// ----------------------------------------------------------------------------
// Cross-correlation lag search package
// Field widths, operation and register codes, sequencer states and the
// structs passed between the top level and the lag engine.
// ----------------------------------------------------------------------------
package xcls_pkg;

    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 16;
    localparam int LAG_CFG_W  = 14;
    localparam int WIN_W      = 13;
    localparam int LAG_W      = 15;
    localparam int SUM_W      = 44;
    localparam int CNT_W      = 13;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int CMP_W      = SUM_W + CNT_W + 1;
    localparam int IDX_W      = LAG_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 80;

    localparam logic [LAG_CFG_W-1:0] MAX_LAG_RESET = 14'd10000;
    localparam logic [WIN_W-1:0]     WINDOW_RESET  = 13'd5000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_REF = 2'd0,
        OP_LOAD_SEC = 2'd1,
        OP_SEARCH   = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_LAG_INIT,
        S_RUN,
        S_DRAIN,
        S_MUL,
        S_CMP,
        S_NEXT,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } eng_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

    typedef struct packed {
        logic                    found;
        logic signed [LAG_W-1:0] best_lag;
        logic signed [SUM_W-1:0] best_sum;
        logic [CNT_W-1:0]        best_count;
    } eng_result_t;

endpackage

// File: rtl/xcls_sample_mem.sv
// ----------------------------------------------------------------------------
// Sample memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module xcls_sample_mem
    import xcls_pkg::*;
#(
    parameter int DEPTH = 16384
)
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic signed [SAMPLE_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic signed [SAMPLE_W-1:0] rdata
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    // Write the appended sample
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/xcls_lag_engine.sv
// ----------------------------------------------------------------------------
// Lag engine
// Walks the lags in increasing order, streams both sample memories through
// a multiply-accumulate pipeline and keeps the lag with the best mean
// product, compared exactly by cross-multiplying sums and counts.
// ----------------------------------------------------------------------------
`include "cross_correlation_lag_search_defines.svh"

module xcls_lag_engine
    import xcls_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 16384
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  eng_ctrl_t                          ctrl,
    output eng_status_t                        status,
    input  logic [$clog2(SAMPLE_DEPTH+1)-1:0]  ref_len,
    input  logic [$clog2(SAMPLE_DEPTH+1)-1:0]  sec_len,
    input  logic [LAG_CFG_W-1:0]               max_lag,
    input  logic [WIN_W-1:0]                   window_limit,
    output logic [$clog2(SAMPLE_DEPTH)-1:0]    ref_raddr,
    output logic [$clog2(SAMPLE_DEPTH)-1:0]    sec_raddr,
    input  logic signed [SAMPLE_W-1:0]         ref_rdata,
    input  logic signed [SAMPLE_W-1:0]         sec_rdata,
    output eng_result_t                        result
);

    localparam int LW = $clog2(SAMPLE_DEPTH + 1);
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int MW = (LW > LAG_CFG_W) ? LW : LAG_CFG_W;
    localparam int HW = MW + 2;

    eng_state_t state_reg, state_next;

    logic [LAG_CFG_W-1:0]     span_reg;
    logic [WIN_W-1:0]         test_len_reg;
    logic signed [LAG_W-1:0]  lag_reg;
    logic [WIN_W-1:0]         i_reg;
    logic [WIN_W-1:0]         hi_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     rd_v_reg;
    logic                     prod_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [CMP_W-1:0]  cand_a_reg;
    logic signed [CMP_W-1:0]  cand_b_reg;
    logic                     found_reg;
    logic signed [LAG_W-1:0]  best_lag_reg;
    logic signed [SUM_W-1:0]  best_sum_reg;
    logic [CNT_W-1:0]         best_count_reg;

    logic [LW-1:0]            min_len;
    logic [MW-1:0]            min_ext;
    logic [LAG_CFG_W-1:0]     span_next;
    logic [WIN_W-1:0]         test_len_next;
    logic signed [LAG_W-1:0]  lag_neg;
    logic [LAG_CFG_W-1:0]     lo;
    logic signed [HW-1:0]     hi_raw;
    logic signed [HW-1:0]     hi_s;
    logic signed [HW-1:0]     lo_s;
    logic signed [HW-1:0]     test_s;
    logic                     skip;
    logic                     run_last;
    logic                     at_end;
    logic signed [IDX_W-1:0]  sec_idx;
    logic signed [CNT_W:0]    best_count_s;
    logic signed [CNT_W:0]    count_s;
    logic                     issue;

    // Lag span and window length from the store lengths
    always_comb
    begin
        min_len = (ref_len < sec_len) ? ref_len : sec_len;
        min_ext = MW'(min_len);
        if (min_ext < MW'(max_lag))
        begin
            span_next = LAG_CFG_W'(min_ext >> 1);
        end
        else
        begin
            span_next = max_lag;
        end
        if (min_ext < MW'(window_limit))
        begin
            test_len_next = WIN_W'(min_ext);
        end
        else
        begin
            test_len_next = window_limit;
        end
    end

    // Overlap bounds of the current lag
    always_comb
    begin
        lag_neg = -lag_reg;
        lo      = lag_reg[LAG_W-1] ? lag_neg[LAG_CFG_W-1:0] : '0;
        lo_s    = signed'(HW'(lo));
        test_s  = signed'(HW'(test_len_reg));
        hi_raw  = signed'(HW'(sec_len)) - HW'(lag_reg);
        hi_s    = (hi_raw > test_s) ? test_s : hi_raw;
        skip    = (hi_s <= lo_s);
    end

    // Read addresses and loop ends
    always_comb
    begin
        sec_idx      = signed'(IDX_W'(i_reg)) + IDX_W'(lag_reg);
        ref_raddr    = AW'(i_reg);
        sec_raddr    = AW'(unsigned'(sec_idx));
        run_last     = (i_reg == hi_reg - WIN_W'(1));
        at_end       = (lag_reg == signed'({1'b0, span_reg}));
        best_count_s = signed'({1'b0, best_count_reg});
        count_s      = signed'({1'b0, count_reg});
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
            if (state_reg == S_SETUP)
            begin
                found_reg <= 1'b0;
            end
            else if (state_reg == S_CMP && (!found_reg || cand_a_reg > cand_b_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (ctrl.start) state_next = S_SETUP;
            S_SETUP:    state_next = S_LAG_INIT;
            S_LAG_INIT: state_next = skip ? S_NEXT : S_RUN;
            S_RUN:      if (run_last) state_next = S_DRAIN;
            S_DRAIN:    if (!rd_v_reg && !prod_v_reg) state_next = S_MUL;
            S_MUL:      state_next = S_CMP;
            S_CMP:      state_next = S_NEXT;
            S_NEXT:     state_next = at_end ? S_DONE : S_LAG_INIT;
            S_DONE:     if (ctrl.ack) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        issue       = (state_reg == S_RUN);
        status.busy = (state_reg != S_IDLE);
        status.done = (state_reg == S_DONE);
    end

    // Lag walk, multiply-accumulate and best-lag datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= ref_rdata * sec_rdata;
        if (state_reg == S_LAG_INIT)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
        unique case (state_reg)
            S_SETUP:
            begin
                span_reg       <= span_next;
                test_len_reg   <= test_len_next;
                lag_reg        <= -signed'({1'b0, span_next});
                best_lag_reg   <= '0;
                best_sum_reg   <= '0;
                best_count_reg <= '0;
            end
            S_LAG_INIT:
            begin
                i_reg     <= WIN_W'(lo);
                hi_reg    <= WIN_W'(hi_s);
                count_reg <= CNT_W'(hi_s - lo_s);
            end
            S_RUN:
            begin
                i_reg <= i_reg + WIN_W'(1);
            end
            S_MUL:
            begin
                cand_a_reg <= acc_reg * best_count_s;
                cand_b_reg <= best_sum_reg * count_s;
            end
            S_CMP:
            begin
                if (!found_reg || cand_a_reg > cand_b_reg)
                begin
                    best_lag_reg   <= lag_reg;
                    best_sum_reg   <= acc_reg;
                    best_count_reg <= count_reg;
                end
            end
            S_NEXT:
            begin
                if (!at_end)
                begin
                    lag_reg <= lag_reg + 15'sd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Drive the result
    always_comb
    begin
        result.found      = found_reg;
        result.best_lag   = best_lag_reg;
        result.best_sum   = best_sum_reg;
        result.best_count = best_count_reg;
    end

    `XCLS_ASSERT_NOW(a_run_in_window, state_reg == S_RUN, i_reg < hi_reg,
        "read index left the overlap window")
    `XCLS_ASSERT_NEXT(a_no_stray_read, state_reg != S_RUN, !rd_v_reg,
        "memory read issued outside the run phase")
    `XCLS_ASSERT_NOW(a_drained_before_mul, state_reg == S_MUL, !rd_v_reg && !prod_v_reg,
        "compare started before the accumulator drained")
    `XCLS_ASSERT_NOW(a_found_count, found_reg && state_reg == S_DONE, best_count_reg != '0,
        "best lag kept with no products")

endmodule

// File: rtl/cross_correlation_lag_search.sv
// ----------------------------------------------------------------------------
// Cross-correlation lag search
// Loads a reference and a second signal into two sample memories and, on a
// search command, returns the lag with the highest mean product.
//
//   Channel   Direction  Handshake                Contents
//   s_*       in         s_tvalid / s_tready      load reference, load second, search
//   m_*       out        m_tvalid / m_tready      best lag, sum, count, flags
//   cfg_*     in         cfg_valid / cfg_ready    max_lag, window_limit writes
//
// Loads are taken back to back while no search is running.
// A search walks every lag, streaming the overlap of each through one memory
// read port per signal; a lag without overlap is skipped. s_tready stays low
// until the search result enters the output register. The output register
// holds while m_tready is low; loads proceed meanwhile. Reset clears lengths
// and the overflow flag; no memory sweep.
// ----------------------------------------------------------------------------
module cross_correlation_lag_search
    import xcls_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 16384
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] sample
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [14:0] best_lag, [58:15] best_sum,
                                             // [71:59] best_count, [72] overflowed,
                                             // [79:73] zero
    output logic                  m_tuser,   // [0] found
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = $clog2(SAMPLE_DEPTH + 1);
    localparam int AW = $clog2(SAMPLE_DEPTH);

    logic [LW-1:0]          ref_len_reg;
    logic [LW-1:0]          sec_len_reg;
    logic                   overflow_reg;
    logic [LAG_CFG_W-1:0]   max_lag_reg;
    logic [WIN_W-1:0]       window_reg;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   accept;
    op_t                    op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                   ref_full;
    logic                   sec_full;
    logic                   ref_we;
    logic                   sec_we;
    logic                   out_free;
    eng_ctrl_t              eng_ctrl;
    eng_status_t            eng_status;
    eng_result_t            eng_result;
    logic [AW-1:0]          ref_raddr;
    logic [AW-1:0]          sec_raddr;
    logic signed [SAMPLE_W-1:0] ref_rdata;
    logic signed [SAMPLE_W-1:0] sec_rdata;

    // Decode the input transfer
    always_comb
    begin
        s_tready     = !eng_status.busy;
        accept       = s_tvalid && s_tready;
        op           = op_t'(s_tuser);
        sample       = signed'(s_tdata[SAMPLE_W-1:0]);
        ref_full     = (ref_len_reg >= LW'(SAMPLE_DEPTH));
        sec_full     = (sec_len_reg >= LW'(SAMPLE_DEPTH));
        ref_we       = accept && (op == OP_LOAD_REF) && !ref_full;
        sec_we       = accept && (op == OP_LOAD_SEC) && !sec_full;
        out_free     = !m_tvalid_reg || m_tready;
        eng_ctrl.start = accept && (op == OP_SEARCH);
        eng_ctrl.ack   = eng_status.done && out_free;
        cfg_ready    = 1'b1;
    end

    // Track store lengths and overflow; empty both stores after a search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg  <= '0;
            sec_len_reg  <= '0;
            overflow_reg <= 1'b0;
        end
        else if (eng_ctrl.ack)
        begin
            ref_len_reg  <= '0;
            sec_len_reg  <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            unique case (op)
                OP_LOAD_REF:
                begin
                    if (ref_full)
                    begin
                        overflow_reg <= 1'b1;
                    end
                    else
                    begin
                        ref_len_reg <= ref_len_reg + LW'(1);
                    end
                end
                OP_LOAD_SEC:
                begin
                    if (sec_full)
                    begin
                        overflow_reg <= 1'b1;
                    end
                    else
                    begin
                        sec_len_reg <= sec_len_reg + LW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lag_reg <= MAX_LAG_RESET;
            window_reg  <= WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_LAG: max_lag_reg <= cfg_data[LAG_CFG_W-1:0];
                CFG_WINDOW:  window_reg  <= cfg_data[WIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (eng_ctrl.ack)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (eng_ctrl.ack)
        begin
            m_tdata_reg <= {7'd0, overflow_reg, eng_result.best_count,
                            eng_result.best_sum, eng_result.best_lag};
            m_tuser_reg <= eng_result.found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    xcls_sample_mem #(
        .DEPTH (SAMPLE_DEPTH)
    ) u_ref_mem (
        .clk   (clk),
        .we    (ref_we),
        .waddr (AW'(ref_len_reg)),
        .wdata (sample),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    xcls_sample_mem #(
        .DEPTH (SAMPLE_DEPTH)
    ) u_sec_mem (
        .clk   (clk),
        .we    (sec_we),
        .waddr (AW'(sec_len_reg)),
        .wdata (sample),
        .raddr (sec_raddr),
        .rdata (sec_rdata)
    );

    xcls_lag_engine #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (eng_ctrl),
        .status       (eng_status),
        .ref_len      (ref_len_reg),
        .sec_len      (sec_len_reg),
        .max_lag      (max_lag_reg),
        .window_limit (window_reg),
        .ref_raddr    (ref_raddr),
        .sec_raddr    (sec_raddr),
        .ref_rdata    (ref_rdata),
        .sec_rdata    (sec_rdata),
        .result       (eng_result)
    );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Cross-correlation lag search testbench
// Drives load and search commands into the stream input, writes the lag and
// window registers between phases, and checks each search result against a
// scoreboard that recomputes the best-mean lag from its own copy of both
// sample stores. Covers extremes, ties, empty stores, ignored commands,
// store overflow, a long receiver hold-off and random traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import xcls_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int DEPTH          = 16384;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int DRAIN_CYCLES   = 64;
    localparam int TIMEOUT_CYCLES = 3000000;
    localparam int IDLE_PCT       = 21;
    localparam int REPORT_LIMIT   = 10;

    // Unused command code: the block must ignore it
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of both stores, lengths, flag and registers
    // ------------------------------------------------------------------------
    class lag_search_scoreboard;
        typedef struct packed {
            logic [LAG_W-1:0] lag;
            logic [SUM_W-1:0] sum;
            logic [CNT_W-1:0] count;
            logic             found;
            logic             ovf;
        } search_result_t;

        logic [SAMPLE_W-1:0] ref_mem [DEPTH];
        logic [SAMPLE_W-1:0] sec_mem [DEPTH];
        int                  ref_len;
        int                  sec_len;
        bit                  ovf_seen;
        int                  max_lag;
        int                  window;
        search_result_t      search_results_q[$];
        int                  errors;

        function new();
            ref_len  = 0;
            sec_len  = 0;
            ovf_seen = 1'b0;
            max_lag  = int'(MAX_LAG_RESET);
            window   = int'(WINDOW_RESET);
            errors   = 0;
        endfunction

        function int pending();
            return search_results_q.size();
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_MAX_LAG)
                max_lag = int'(val[LAG_CFG_W-1:0]);
            else
                window = int'(val[WIN_W-1:0]);
        endfunction

        // Walk every lag, keep the best mean by cross-multiplied comparison
        function search_result_t predict_search();
            search_result_t r;
            longint min_len;
            longint span;
            longint test_len;
            longint lo;
            longint hi;
            longint acc;
            longint cnt;
            longint best_lag;
            longint best_sum;
            longint best_cnt;
            bit     hit;
            min_len  = (ref_len < sec_len) ? ref_len : sec_len;
            span     = max_lag;
            test_len = (min_len < window) ? min_len : window;
            best_lag = 0;
            best_sum = 0;
            best_cnt = 0;
            hit      = 1'b0;
            if (min_len < span)
                span = min_len / 2;
            for (longint lag = -span; lag <= span; lag++)
            begin
                lo = (lag < 0) ? -lag : 0;
                hi = sec_len - lag;
                if (hi > test_len)
                    hi = test_len;
                if (hi <= lo)
                    continue;
                acc = 0;
                for (longint i = lo; i < hi; i++)
                    acc += longint'($signed(ref_mem[i])) * longint'($signed(sec_mem[i + lag]));
                cnt = hi - lo;
                if (!hit || acc * best_cnt > best_sum * cnt)
                begin
                    hit      = 1'b1;
                    best_lag = lag;
                    best_sum = acc;
                    best_cnt = cnt;
                end
            end
            r.lag   = best_lag[LAG_W-1:0];
            r.sum   = best_sum[SUM_W-1:0];
            r.count = best_cnt[CNT_W-1:0];
            r.found = hit;
            r.ovf   = ovf_seen;
            return r;
        endfunction

        // Update the stores for one accepted input transfer
        function void note_input(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp);
            if (op == OP_LOAD_REF)
            begin
                if (ref_len < DEPTH)
                    ref_mem[ref_len++] = smp;
                else
                    ovf_seen = 1'b1;
            end
            else if (op == OP_LOAD_SEC)
            begin
                if (sec_len < DEPTH)
                    sec_mem[sec_len++] = smp;
                else
                    ovf_seen = 1'b1;
            end
            else if (op == OP_SEARCH)
            begin
                search_results_q.insert(search_results_q.size(), predict_search());
                ref_len  = 0;
                sec_len  = 0;
                ovf_seen = 1'b0;
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic found_bit);
            search_result_t got;
            search_result_t want;
            got.lag   = data[14:0];
            got.sum   = data[58:15];
            got.count = data[71:59];
            got.ovf   = data[72];
            got.found = found_bit;
            if (search_results_q.size() == 0)
            begin
                report($sformatf("result with no search pending: lag %0d sum %0d count %0d",
                                 $signed(got.lag), $signed(got.sum), got.count));
                return;
            end
            want = search_results_q.pop_front();
            if (got.lag !== want.lag || got.sum !== want.sum || got.count !== want.count ||
                got.found !== want.found || got.ovf !== want.ovf)
                report($sformatf({"lag exp %0d got %0d, sum exp %0d got %0d, ",
                                  "count exp %0d got %0d, found exp %0d got %0d, ",
                                  "overflow exp %0d got %0d"},
                                 $signed(want.lag), $signed(got.lag),
                                 $signed(want.sum), $signed(got.sum),
                                 want.count, got.count, want.found, got.found,
                                 want.ovf, got.ovf));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [15:0] sample
    logic [OP_W-1:0]       s_tuser   = '0;   // [1:0] operation
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [14:0] lag, [58:15] sum, [71:59] count,
                                             // [72] overflowed
    logic                  m_tuser;          // [0] found
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit tx_steady  = 1'b0;
    bit rx_steady  = 1'b0;
    int hold_asked = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int rand_items = 0;

    lag_search_scoreboard sb = new();

    always #(CLK_PERIOD / 2) clk = ~clk;

    cross_correlation_lag_search #(
        .SAMPLE_DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Receiver: random backpressure, plus a counted hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Hard stop
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one item after a random gap, hold until the transfer
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, smp);
    endtask

    // Drop valid and wait until every search result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one register write and hold until the transfer; the caller drops valid
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_config(idx, val);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] lag_val,
                            input logic [CFG_DATA_W-1:0] win_val);
        wait_idle();
        write_reg(CFG_MAX_LAG, lag_val);
        write_reg(CFG_WINDOW, win_val);
        cfg_valid <= 1'b0;
    endtask

    // Load one reference and one second signal, interleaved or reference first, then search.
    // A related second signal is a shifted, slightly perturbed reference.
    task automatic run_set(input int n_ref, input int n_sec, input bit related);
        logic [SAMPLE_W-1:0] ref_q[$];
        logic [SAMPLE_W-1:0] sec_q[$];
        int                  shift;
        int                  src;
        int                  k;
        bit                  ref_first;
        shift     = int'($urandom_range(8)) - 4;
        ref_first = ($urandom_range(3) == 0);
        for (k = 0; k < n_ref; k++)
            ref_q.insert(ref_q.size(), pick_sample());
        for (k = 0; k < n_sec; k++)
        begin
            src = k - shift;
            if (related && src >= 0 && src < n_ref)
                sec_q.insert(sec_q.size(), ref_q[src] ^ SAMPLE_W'($urandom_range(3)));
            else
                sec_q.insert(sec_q.size(), pick_sample());
        end
        while (ref_q.size() + sec_q.size() != 0)
        begin
            if ($urandom_range(99) < 3)
                send_item(OP_IGNORED, pick_sample());
            if (sec_q.size() == 0 ||
                (ref_q.size() != 0 && (ref_first || $urandom_range(1) == 0)))
                send_item(OP_LOAD_REF, ref_q.pop_front());
            else
                send_item(OP_LOAD_SEC, sec_q.pop_front());
            rand_items++;
        end
        send_item(OP_SEARCH, pick_sample());
        rand_items++;
    endtask

    // Mostly small related sets, a few large ones, some with a store left empty
    task automatic run_random_set();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            run_set($urandom_range(60, 120), $urandom_range(60, 120), 1'b1);
        else if (pick < 12)
            run_set($urandom_range(1) ? $urandom_range(0, 8) : 0,
                    $urandom_range(1) ? 0 : $urandom_range(0, 8), 1'b0);
        else
            run_set($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(3) != 0);
    endtask

    // Fill one store past its depth, load a few into the other, then search
    task automatic overflow_store(input logic [OP_W-1:0] full_op,
                                  input logic [OP_W-1:0] short_op, input int n_short);
        int k;
        for (k = 0; k < DEPTH + 2; k++)
            send_item(full_op, pick_sample());
        for (k = 0; k < n_short; k++)
            send_item(short_op, pick_sample());
        send_item(OP_SEARCH, 16'h0000);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty search and an ignored command
        send_item(OP_SEARCH, 16'hA5A5);
        send_item(OP_IGNORED, 16'h8000);

        // Full-scale samples of both signs
        send_item(OP_LOAD_REF, 16'h7FFF);
        send_item(OP_LOAD_REF, 16'h8000);
        send_item(OP_LOAD_REF, 16'h8000);
        send_item(OP_LOAD_REF, 16'h7FFF);
        send_item(OP_LOAD_SEC, 16'h8000);
        send_item(OP_LOAD_SEC, 16'h8000);
        send_item(OP_IGNORED, 16'hFFFF);
        send_item(OP_LOAD_SEC, 16'h7FFF);
        send_item(OP_LOAD_SEC, 16'hFFFF);
        send_item(OP_SEARCH, 16'h5A5A);

        // Constant signals: every lag ties, the most negative one wins
        repeat (3) send_item(OP_LOAD_REF, 16'h0064);
        repeat (3) send_item(OP_LOAD_SEC, 16'h0064);
        send_item(OP_SEARCH, 16'h0000);

        // One store left empty
        send_item(OP_LOAD_REF, 16'h1234);
        send_item(OP_LOAD_REF, 16'hFFFF);
        send_item(OP_SEARCH, 16'h0000);
        send_item(OP_LOAD_SEC, 16'h0001);
        send_item(OP_SEARCH, 16'hFFFF);

        // Both stores past their depth
        overflow_store(OP_LOAD_REF, OP_LOAD_SEC, 3);
        overflow_store(OP_LOAD_SEC, OP_LOAD_REF, 5);

        // Receiver holds off while searches queue up behind the output register
        wait_idle();
        hold_asked <= hold_asked + 1;
        tx_steady  <= 1'b1;
        @(posedge clk);
        repeat (3) run_set($urandom_range(3, 6), $urandom_range(3, 6), 1'b1);
        tx_steady <= 1'b0;

        // Register extremes, including a zero window and the top data bit
        set_regs(14'h3FFF, 14'h3FFF);
        repeat (4) run_random_set();
        set_regs(14'd0, 14'd8191);
        repeat (4) run_random_set();
        set_regs(14'd1, 14'd0);
        repeat (4) run_random_set();
        set_regs(14'd16383, 14'd1);
        repeat (4) run_random_set();
        set_regs(14'd2, 14'd2);
        repeat (4) run_random_set();

        // No idling on either side
        set_regs(14'd10000, 14'd5000);
        tx_steady <= 1'b1;
        rx_steady <= 1'b1;
        repeat (6) run_random_set();
        tx_steady <= 1'b0;
        rx_steady <= 1'b0;

        // Random traffic with a new setting every few searches
        while (rand_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(3))
                0:       set_regs(14'($urandom_range(0, 3)), 14'($urandom_range(0, 3)));
                1:       set_regs(14'($urandom_range(0, 40)), 14'($urandom_range(1, 40)));
                2:       set_regs(14'($urandom), 14'($urandom));
                default: set_regs(14'd16383, 14'd8191);
            endcase
            repeat ($urandom_range(3, 8)) run_random_set();
        end

        // Drain
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
